### src/nsf_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Shared types, character codes and decode helpers for the framer modules.
// ----------------------------------------------------------------------------
package nsf_pkg;

  // Highest field count that the field total may reach.
  localparam logic [5:0] MAX_FIELDS = 6'd32;
  localparam logic [5:0] FIELD_IDX_MAX = 6'd63;

  // Output word layout: fields packed from bit 0 upward, padded to bytes.
  localparam int unsigned RES_BITS  = 75;
  localparam int unsigned TDATA_W   = ((RES_BITS + 7) / 8) * 8;

  // Character codes.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_FIELD = 3'd2,
    PH_SUM   = 3'd3,
    PH_TERM  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2
  } event_t;

  // Sentence type codes.
  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_GGA     = 3'd1;
  localparam logic [2:0] KIND_RMC     = 3'd2;
  localparam logic [2:0] KIND_GSV     = 3'd3;
  localparam logic [2:0] KIND_GSA     = 3'd4;
  localparam logic [2:0] KIND_GLL     = 3'd5;
  localparam logic [2:0] KIND_VTG     = 3'd6;

  // One result of the framer, carried from the parser to the output register.
  typedef struct packed {
    logic [15:0] sum_errors_total;
    logic [15:0] sentences_total;
    logic [5:0]  payload_field;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        sum_matches;
    logic [7:0]  received_sum;
    logic [7:0]  computed_sum;
    logic [5:0]  fields_seen;
    logic [2:0]  sentence_kind;
    event_t      event_res;
  } result_t;

  // Maps the three type characters to a sentence kind.
  function automatic logic [2:0] classify(input logic [23:0] t);
    logic [2:0] k;
    k = KIND_UNKNOWN;
    case (t)
      24'h474741: k = KIND_GGA;
      24'h524D43: k = KIND_RMC;
      24'h475356: k = KIND_GSV;
      24'h475341: k = KIND_GSA;
      24'h474C4C: k = KIND_GLL;
      24'h565447: k = KIND_VTG;
      default:    k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // Hex digit value in bits 3:0; bit 4 set for a character that is not a digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] v;
    d = 8'd0;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      v = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      v = {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      v = {1'b0, d[3:0]};
    end
    return v;
  endfunction

endpackage

### src/nmea_sentence_framer.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer
// Byte-serial NMEA 0183 framer: classifies the sentence type, counts fields,
// checks the XOR checksum and forwards field bytes with their field index.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_*       in         tdata[7:0] rx_byte, one request per received character
//  m_*       out        tdata[79:0] one result request per received character
//
// Every accepted byte produces exactly one result. A byte waits in the input
// register, is parsed while the sentence state updates, and lands in the
// output register; the framer sustains one byte per cycle while m_tready
// stays high.
// The input side keeps accepting while a result waits downstream; a stall on
// m_tready holds the parser and backs up only once both registers are full.
// rst is synchronous and active high; it returns the parser to waiting for
// a dollar sign and clears the sentence and error counters.
// ----------------------------------------------------------------------------
module nmea_sentence_framer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [1:0] event_res, [4:2] sentence_kind, [10:5] fields_seen,
  // [18:11] computed_sum, [26:19] received_sum, [27] sum_matches,
  // [35:28] payload_byte, [36] payload_valid, [42:37] payload_field,
  // [58:43] sentences_total, [74:59] sum_errors_total, [79:75] zero
  output logic [nsf_pkg::TDATA_W-1:0]  m_tdata
);
  import nsf_pkg::*;

  logic       held;
  logic [7:0] held_byte;
  logic       out_free;
  logic       advance;
  result_t    res;

  // The parser moves one byte whenever one is held and the output has room;
  // its state registers update on the same edge.
  assign advance = held && out_free;

  nsf_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .take      (advance),
    .held      (held),
    .held_byte (held_byte)
  );

  nsf_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .c    (held_byte),
    .res  (res)
  );

  nsf_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // An accepted sentence always has a known type and a good checksum.
  a_accept_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == EV_ACCEPT) |-> (m_tdata[27] && m_tdata[4:2] != KIND_UNKNOWN))
    else $error("accepted sentence without match or known kind");

  // A forwarded field byte never coincides with a sentence event.
  a_payload_no_event: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[36]) |-> (m_tdata[1:0] == EV_NONE))
    else $error("payload byte carries an event");

  // The field total saturates at the field limit.
  a_fields_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:5] <= MAX_FIELDS))
    else $error("field total beyond limit");

  // The parser never steps without a held byte.
  a_step_needs_byte: assert property (@(posedge clk) disable iff (rst)
    advance |-> held)
    else $error("parser stepped with no byte");

endmodule

### src/nsf_in_reg.sv
// ----------------------------------------------------------------------------
// NMEA framer input register
// Holds one received byte until the parser can move it on.
// ----------------------------------------------------------------------------
module nsf_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       take,
  output logic       held,
  output logic [7:0] held_byte
);
  import nsf_pkg::*;

  logic       valid;
  logic [7:0] data;

  // Room for a new byte when empty or when the held byte leaves this cycle.
  assign s_tready  = !valid || take;
  assign held      = valid;
  assign held_byte = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data <= s_tdata;
    end
  end

endmodule

### src/nsf_parser.sv
// ----------------------------------------------------------------------------
// NMEA framer parser
// Sentence state machine: address capture, field counting, checksum decode.
// ----------------------------------------------------------------------------
module nsf_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      c,
  output nsf_pkg::result_t res
);
  import nsf_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  addr_count, addr_count_next;
  logic [23:0] addr_chars, addr_chars_next;
  logic [2:0]  kind, kind_next;
  logic [7:0]  xor_acc, xor_acc_next;
  logic [7:0]  hex_first, hex_first_next;
  logic        hex_count, hex_count_next;
  logic [5:0]  field_index, field_index_next;
  logic [5:0]  field_total, field_total_next;
  logic [7:0]  recv_sum, recv_sum_next;
  logic        match_flag, match_flag_next;
  logic        no_sum_end, no_sum_end_next;
  logic [15:0] sent_cnt, sent_cnt_next;
  logic [15:0] err_cnt, err_cnt_next;

  logic [4:0]  hi_digit;
  logic [4:0]  lo_digit;
  logic [7:0]  sum_dec;
  logic [5:0]  closed_total;
  event_t      ev;
  logic        pv;
  logic [7:0]  pb;
  logic [5:0]  pf;

  assign hi_digit = hex_value(hex_first);
  assign lo_digit = hex_value(c);
  assign sum_dec  = (hi_digit[4] || lo_digit[4]) ? 8'hFF : {hi_digit[3:0], lo_digit[3:0]};
  // Closing a field only raises the total while the index is under the limit.
  assign closed_total = (field_index < MAX_FIELDS) ? field_index + 6'd1 : field_total;

  always_comb begin
    phase_next       = phase;
    addr_count_next  = addr_count;
    addr_chars_next  = addr_chars;
    kind_next        = kind;
    xor_acc_next     = xor_acc;
    hex_first_next   = hex_first;
    hex_count_next   = hex_count;
    field_index_next = field_index;
    field_total_next = field_total;
    recv_sum_next    = recv_sum;
    match_flag_next  = match_flag;
    no_sum_end_next  = no_sum_end;
    sent_cnt_next    = sent_cnt;
    err_cnt_next     = err_cnt;
    ev = EV_NONE;
    pv = 1'b0;
    pb = 8'd0;
    pf = 6'd0;

    case (phase)
      PH_IDLE: begin
        if (c == CH_DOLLAR) begin
          addr_count_next  = 3'd0;
          addr_chars_next  = 24'd0;
          kind_next        = KIND_UNKNOWN;
          xor_acc_next     = 8'd0;
          hex_first_next   = 8'd0;
          hex_count_next   = 1'b0;
          field_index_next = 6'd0;
          field_total_next = 6'd0;
          recv_sum_next    = 8'd0;
          match_flag_next  = 1'b0;
          no_sum_end_next  = 1'b0;
          phase_next       = PH_ADDR;
        end
      end
      PH_ADDR: begin
        xor_acc_next = xor_acc ^ c;
        if (addr_count < 3'd5) begin
          addr_chars_next = {addr_chars[15:0], c};
          addr_count_next = addr_count + 3'd1;
        end else begin
          // The byte after the address is the separator and opens field 0.
          kind_next        = classify(addr_chars);
          field_index_next = 6'd0;
          phase_next       = PH_FIELD;
        end
      end
      PH_FIELD: begin
        if (c == CH_COMMA) begin
          field_total_next = closed_total;
          if (field_index < FIELD_IDX_MAX) begin
            field_index_next = field_index + 6'd1;
          end
          xor_acc_next = xor_acc ^ c;
        end else if (c == CH_STAR) begin
          field_total_next = closed_total;
          hex_count_next   = 1'b0;
          hex_first_next   = 8'd0;
          phase_next       = PH_SUM;
        end else if (c == CH_CR || c == CH_LF) begin
          field_total_next = closed_total;
          recv_sum_next    = 8'd0;
          match_flag_next  = 1'b1;
          no_sum_end_next  = 1'b1;
          sent_cnt_next    = sent_cnt + 16'd1;
          ev = (kind != KIND_UNKNOWN) ? EV_ACCEPT : EV_NONE;
          phase_next = (c == CH_CR) ? PH_TERM : PH_IDLE;
        end else begin
          xor_acc_next = xor_acc ^ c;
          pv = 1'b1;
          pb = c;
          pf = field_index;
        end
      end
      PH_SUM: begin
        if (!hex_count) begin
          hex_first_next = c;
          hex_count_next = 1'b1;
        end else begin
          recv_sum_next   = sum_dec;
          match_flag_next = (sum_dec == xor_acc);
          if (sum_dec != xor_acc) begin
            err_cnt_next = err_cnt + 16'd1;
          end
          sent_cnt_next   = sent_cnt + 16'd1;
          no_sum_end_next = 1'b0;
          phase_next      = PH_TERM;
        end
      end
      PH_TERM: begin
        if (c != CH_CR) begin
          phase_next = PH_IDLE;
          // A sentence without a checksum was already reported at its CR.
          if (!no_sum_end) begin
            if (c == CH_LF) begin
              ev = match_flag ? ((kind != KIND_UNKNOWN) ? EV_ACCEPT : EV_NONE) : EV_REJECT;
            end else begin
              ev = (kind != KIND_UNKNOWN && match_flag) ? EV_ACCEPT : EV_REJECT;
            end
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    res.event_res        = ev;
    res.sentence_kind    = kind_next;
    res.fields_seen      = field_total_next;
    res.computed_sum     = xor_acc_next;
    res.received_sum     = recv_sum_next;
    res.sum_matches      = match_flag_next;
    res.payload_byte     = pb;
    res.payload_valid    = pv;
    res.payload_field    = pf;
    res.sentences_total  = sent_cnt_next;
    res.sum_errors_total = err_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      addr_count  <= 3'd0;
      addr_chars  <= 24'd0;
      kind        <= KIND_UNKNOWN;
      xor_acc     <= 8'd0;
      hex_first   <= 8'd0;
      hex_count   <= 1'b0;
      field_index <= 6'd0;
      field_total <= 6'd0;
      recv_sum    <= 8'd0;
      match_flag  <= 1'b0;
      no_sum_end  <= 1'b0;
      sent_cnt    <= 16'd0;
      err_cnt     <= 16'd0;
    end else if (step) begin
      phase       <= phase_next;
      addr_count  <= addr_count_next;
      addr_chars  <= addr_chars_next;
      kind        <= kind_next;
      xor_acc     <= xor_acc_next;
      hex_first   <= hex_first_next;
      hex_count   <= hex_count_next;
      field_index <= field_index_next;
      field_total <= field_total_next;
      recv_sum    <= recv_sum_next;
      match_flag  <= match_flag_next;
      no_sum_end  <= no_sum_end_next;
      sent_cnt    <= sent_cnt_next;
      err_cnt     <= err_cnt_next;
    end
  end

endmodule

### src/nsf_out_reg.sv
// ----------------------------------------------------------------------------
// NMEA framer output register
// Holds one result and packs it onto the master-side stream.
// ----------------------------------------------------------------------------
module nsf_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  nsf_pkg::result_t               res,
  output logic                           free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [nsf_pkg::TDATA_W-1:0]    m_tdata
);
  import nsf_pkg::*;

  logic    valid;
  result_t data;

  // A new result may enter when empty or when the held one is taken now.
  assign free     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = {{(TDATA_W - RES_BITS){1'b0}}, data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule
